/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

/* sv/sofl_pkg.sv */
// ----------------------------------------------------------------------------
// sofl_pkg
// shared types and constants of the free list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package sofl_pkg;

  localparam int MaxFreeBlocks = 32;
  localparam int PoolBytes     = 4096;
  localparam int HdrSlots      = PoolBytes / 4;
  localparam int IdxW          = $clog2(MaxFreeBlocks);
  localparam int CntW          = $clog2(MaxFreeBlocks + 1);
  localparam int HdrW          = $clog2(HdrSlots);
  localparam int OffW          = $clog2(PoolBytes);
  localparam int SzW           = 13;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_ZEROHDR  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  // header memory command
  typedef struct packed {
    logic            we;
    logic [HdrW-1:0] addr;
    logic [SzW-1:0]  wdata;
  } hdr_cmd_t;

endpackage

`default_nettype wire

/* sv/size_ordered_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// size_ordered_free_list_allocator
// heap allocator with a size ordered free table and coalescing
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low first)                          tuser
//  in_       in   alloc_size[12:0], free_address[44:13]      req_type
//  out_      out  address[31:0], block_bytes[44:32]          status
//  cfg_      in   index 0 pool_base, 1 pool_bytes
// allocate and free run table walks that step one entry per cycle, so the
// time from input transfer to result valid grows with the free count; the
// merge walks use a single shared compare/add unit.
// reset: synchronous, table holds one entry; the header store then runs a
// clearing pass over every slot, also after each pool_bytes write.
// in_tready low while busy, clearing, or while a result waits for out_tready.
`default_nettype none

module size_ordered_free_list_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // alloc_size, free_address
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // address, block_bytes
  output logic [2:0]       out_tuser,  // status
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import sofl_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_AWALK, S_FCHK, S_FHDR, S_FADJ, S_FMRG, S_FDROP,
    S_FPOS, S_FINS, S_DROP, S_OUT
  } st_t;

  st_t             st_r;
  logic [31:0]     base_r;
  logic [12:0]     pbytes_r;
  logic [OffW-1:0] fo_r [MaxFreeBlocks];
  logic [SzW-1:0]  fb_r [MaxFreeBlocks];
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] i_r;
  logic [CntW-1:0] pos_r;
  logic            type_r;
  logic [SzW:0]    req_r;
  logic [31:0]     off_r;
  logic [SzW-1:0]  size_r;
  logic [OffW-1:0] toff_r;
  logic [SzW:0]    tsz_r;
  logic            any_r;
  logic [1:0]      wait_r;
  logic [31:0]     oaddr_r;
  logic [SzW-1:0]  obytes_r;
  logic [2:0]      ostat_r;
  logic            ovld_r;
  logic            clr;
  logic            hbusy;
  hdr_cmd_t        hcmd;
  logic [SzW-1:0]  hrd;

  logic [12:0] cfg_v;
  always_comb begin
    cfg_v = cfg_wdata[12:0];
    if (cfg_v < 13'd16) cfg_v = 13'd16;
    if (cfg_v > 13'(PoolBytes)) cfg_v = 13'(PoolBytes);
    cfg_v = cfg_v & ~13'd3;
  end
  assign clr = cfg_we && cfg_index == CFG_BYTES;

  sofl_hdr_ram u_hdr (.clk, .rst_n, .clr, .cmd(hcmd), .rdata(hrd), .busy(hbusy));

  // shared unit: current entry vs target
  logic [IdxW-1:0] ix;
  logic [OffW-1:0] eo;
  logic [SzW-1:0]  es;
  logic [31:0]     d1, d2;
  logic            adj;
  assign ix  = i_r[IdxW-1:0];
  assign eo  = fo_r[ix];
  assign es  = fb_r[ix];
  assign d1  = 32'(toff_r) - 32'(eo);
  assign d2  = 32'(eo) - 32'(toff_r);
  assign adj = (d1 == 32'(es) + 32'd8) || (d2 == 32'(tsz_r) + 32'd8);

  logic [31:0] foff;
  assign foff = in_tdata[44:13] - 32'd8 - base_r;

  always_comb begin
    hcmd = '0;
    hcmd.addr = off_r[HdrW+1:2];
    if (st_r == S_AWALK && i_r < cnt_r && {1'b0, es} >= req_r) begin
      hcmd.we = 1'b1;
      if ({1'b0, es} < req_r + 14'd12) begin
        hcmd.addr = eo[OffW-1:2];
        hcmd.wdata = es;
      end else begin
        hcmd.addr = HdrW'((32'(eo) + 32'(es) - 32'(req_r)) >> 2);
        hcmd.wdata = req_r[SzW-1:0];
      end
    end else if (st_r == S_FPOS && i_r == '0) begin
      hcmd.we = 1'b1;
    end
  end

  assign in_tready  = st_r == S_IDLE && !ovld_r && !hbusy;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {3'd0, obytes_r, oaddr_r};
  assign out_tuser  = ostat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      base_r   <= '0;
      pbytes_r <= 13'(PoolBytes);
      cnt_r    <= CntW'(1);
      fo_r[0]  <= '0;
      fb_r[0]  <= 13'(PoolBytes - 8);
      ovld_r   <= 1'b0;
    end else begin
      if (ovld_r && out_tready) ovld_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) base_r <= cfg_wdata;
        else begin
          pbytes_r <= cfg_v;
          cnt_r    <= CntW'(1);
          fo_r[0]  <= '0;
          fb_r[0]  <= cfg_v - 13'd8;
        end
      end
      unique case (st_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          type_r <= in_tuser;
          req_r  <= ({1'b0, in_tdata[12:0]} + 14'd3) & ~14'd3;
          off_r  <= foff;
          i_r    <= '0;
          oaddr_r <= '0; obytes_r <= '0; ostat_r <= ST_OK;
          if (!in_tuser) begin
            if (in_tdata[12:0] == '0) begin ostat_r <= ST_ZERO; st_r <= S_OUT; end
            else st_r <= S_AWALK;
          end else st_r <= S_FCHK;
        end
        S_AWALK: begin
          if (i_r >= cnt_r) begin
            ostat_r <= ST_NOSPACE; st_r <= S_OUT;
          end else if ({1'b0, es} >= req_r) begin
            if ({1'b0, es} < req_r + 14'd12) begin
              oaddr_r <= base_r + 32'(eo) + 32'd8;
              obytes_r <= es;
              st_r <= S_DROP;
            end else begin
              oaddr_r <= base_r + 32'(eo) + 32'(es) - 32'(req_r) + 32'd8;
              obytes_r <= req_r[SzW-1:0];
              fb_r[ix] <= es - req_r[SzW-1:0] - 13'd8;
              st_r <= S_OUT;
            end
          end else i_r <= i_r + 1'b1;
        end
        S_DROP: begin
          if (i_r + 1'b1 < cnt_r) begin
            fo_r[ix] <= fo_r[IdxW'(i_r + 1'b1)];
            fb_r[ix] <= fb_r[IdxW'(i_r + 1'b1)];
            i_r <= i_r + 1'b1;
          end else begin
            cnt_r <= cnt_r - 1'b1;
            st_r <= type_r ? S_FMRG : S_OUT;
            i_r <= '0;
          end
        end
        S_FCHK: begin
          if (off_r >= 32'(pbytes_r) || off_r[1:0] != 2'd0) begin
            ostat_r <= ST_RANGE; st_r <= S_OUT;
          end else begin
            wait_r <= 2'd0; st_r <= S_FHDR;
          end
        end
        S_FHDR: begin
          wait_r <= wait_r + 2'd1;
          if (wait_r == 2'd1) begin
            if (hrd == '0) begin ostat_r <= ST_ZEROHDR; st_r <= S_OUT; end
            else begin
              size_r <= hrd; toff_r <= off_r[OffW-1:0];
              tsz_r <= {1'b0, hrd}; any_r <= 1'b0; st_r <= S_FADJ;
            end
          end
        end
        S_FADJ: begin
          if (i_r >= cnt_r) begin
            i_r <= '0;
            if (!any_r && cnt_r >= CntW'(MaxFreeBlocks)) begin
              ostat_r <= ST_FULL; st_r <= S_OUT;
            end else st_r <= S_FMRG;
          end else begin
            if (adj) any_r <= 1'b1;
            i_r <= i_r + 1'b1;
          end
        end
        S_FMRG: begin
          if (i_r >= cnt_r) begin
            i_r <= '0; st_r <= S_FPOS;
          end else if (adj) begin
            if (eo < toff_r) toff_r <= eo;
            tsz_r <= tsz_r + {1'b0, es} + 14'd8;
            st_r <= S_DROP;
          end else i_r <= i_r + 1'b1;
        end
        S_FPOS: begin
          if (i_r >= cnt_r || tsz_r <= {1'b0, es}) begin
            pos_r <= i_r; i_r <= cnt_r; st_r <= S_FINS;
          end else i_r <= i_r + 1'b1;
        end
        S_FINS: begin
          // i_r walks down from count to insert position
          if (i_r != pos_r) begin
            fo_r[ix] <= fo_r[IdxW'(i_r - 1'b1)];
            fb_r[ix] <= fb_r[IdxW'(i_r - 1'b1)];
            i_r <= i_r - 1'b1;
          end else begin
            fo_r[ix] <= toff_r;
            fb_r[ix] <= tsz_r[SzW-1:0];
            cnt_r <= cnt_r + 1'b1;
            obytes_r <= size_r;
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          ovld_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_cnt_max, cnt_r <= CntW'(MaxFreeBlocks), "free count overflow")
  `ASSERT_CLK(a_busy, st_r != S_IDLE |-> !in_tready, "ready while busy")
  `ASSERT_CLK(a_stat, out_tvalid && out_tuser != ST_OK |-> out_tdata[44:0] == '0, "payload on error")

endmodule

`default_nettype wire

/* sv/sofl_hdr_ram.sv */
// ----------------------------------------------------------------------------
// sofl_hdr_ram
// header size store, cleared by a one-entry-per-cycle pass after reset and
// after each reinit
// ----------------------------------------------------------------------------
`default_nettype none

module sofl_hdr_ram (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clr,
  input  wire sofl_pkg::hdr_cmd_t        cmd,
  output logic [sofl_pkg::SzW-1:0]       rdata,
  output logic                           busy
);
  import sofl_pkg::*;

  logic [SzW-1:0]  mem [HdrSlots];
  logic [SzW-1:0]  d_r;
  logic [HdrW-1:0] caddr_r;
  logic            clr_act_r;

  // clearing pass walks every slot once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      caddr_r   <= '0;
    end else if (clr) begin
      clr_act_r <= 1'b1;
      caddr_r   <= '0;
    end else if (clr_act_r) begin
      caddr_r <= caddr_r + HdrW'(1);
      if (caddr_r == '1) clr_act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      mem[caddr_r] <= '0;
    end else if (cmd.we && !clr) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    d_r <= mem[cmd.addr];
  end

  assign rdata = d_r;
  assign busy  = clr_act_r;

endmodule

`default_nettype wire

/* tb/size_ordered_free_list_allocator_tb.sv */
// ----------------------------------------------------------------------------
// size_ordered_free_list_allocator_tb
// checks allocate and free results against an in-bench model of the free
// table, across several pool settings, with random gaps on both streams
// ----------------------------------------------------------------------------
`default_nettype none

class heap_scoreboard;
  logic [31:0] base;
  logic [31:0] bytes;
  logic [31:0] ent_off[$];
  logic [31:0] ent_sz[$];
  logic [12:0] hdr[sofl_pkg::HdrSlots];
  logic [47:0] exp_data[$];
  logic [2:0]  exp_status[$];
  logic [31:0] granted[$];
  int          errors;
  int          shown;

  function new();
    base = 0;
    bytes = sofl_pkg::PoolBytes;
    errors = 0;
    shown = 0;
    clear_table();
  endfunction

  function void clear_table();
    ent_off = {};
    ent_sz = {};
    ent_off.push_back(0);
    ent_sz.push_back(bytes - 8);
    foreach (hdr[k]) hdr[k] = '0;
    granted = {};
  endfunction

  function void set_reg(logic idx, logic [31:0] v);
    logic [31:0] b;
    if (idx == sofl_pkg::CFG_BASE) begin
      base = v;
    end else begin
      b = v & 32'h1fff;
      if (b < 16) b = 16;
      if (b > sofl_pkg::PoolBytes) b = sofl_pkg::PoolBytes;
      bytes = b & ~32'd3;
      clear_table();
    end
  endfunction

  function bit touches(logic [31:0] eo, logic [31:0] es, logic [31:0] to, logic [31:0] ts);
    return (to - eo) == (es + 8) || (eo - to) == (ts + 8);
  endfunction

  function void note_request(logic kind, logic [12:0] asz, logic [31:0] fa);
    logic [31:0] req, off, sz, toff, tsz, pos;
    logic [2:0]  st;
    logic [31:0] addr;
    bit          any, found, done;
    st = sofl_pkg::ST_OK;
    addr = 0;
    sz = 0;
    if (kind == 1'b0) begin
      done = 0;
      if (asz == 0) begin
        st = sofl_pkg::ST_ZERO;
      end else begin
        req = (asz + 3) & ~32'd3;
        for (int i = 0; i < ent_off.size() && !done; i++) begin
          if (ent_sz[i] >= req) begin
            done = 1;
            if (ent_sz[i] < req + 12) begin
              off = ent_off[i];
              sz = ent_sz[i];
              ent_off.delete(i);
              ent_sz.delete(i);
            end else begin
              off = ent_off[i] + ent_sz[i] - req;
              sz = req;
              ent_sz[i] = ent_sz[i] - req - 8;
            end
            hdr[(off >> 2) % sofl_pkg::HdrSlots] = sz;
            addr = base + off + 8;
            granted.push_back(addr);
          end
        end
        if (!done) st = sofl_pkg::ST_NOSPACE;
      end
    end else begin
      off = fa - 8 - base;
      if (off >= bytes || off[1:0] != 0) begin
        st = sofl_pkg::ST_RANGE;
      end else if (hdr[(off >> 2) % sofl_pkg::HdrSlots] == 0) begin
        st = sofl_pkg::ST_ZEROHDR;
      end else begin
        sz = hdr[(off >> 2) % sofl_pkg::HdrSlots];
        any = 0;
        foreach (ent_off[i]) if (touches(ent_off[i], ent_sz[i], off, sz)) any = 1;
        if (!any && ent_off.size() >= sofl_pkg::MaxFreeBlocks) begin
          st = sofl_pkg::ST_FULL;
          sz = 0;
        end else begin
          toff = off;
          tsz = sz;
          do begin
            found = 0;
            for (int i = 0; i < ent_off.size() && !found; i++) begin
              if (touches(ent_off[i], ent_sz[i], toff, tsz)) begin
                if (ent_off[i] < toff) toff = ent_off[i];
                tsz = ent_sz[i] + tsz + 8;
                ent_off.delete(i);
                ent_sz.delete(i);
                found = 1;
              end
            end
          end while (found);
          hdr[(off >> 2) % sofl_pkg::HdrSlots] = 0;
          pos = ent_off.size();
          for (int i = ent_off.size() - 1; i >= 0; i--) if (tsz <= ent_sz[i]) pos = i;
          ent_off.insert(pos, toff);
          ent_sz.insert(pos, tsz);
        end
      end
    end
    exp_data.push_back({3'b0, sz[12:0] & {13{st == sofl_pkg::ST_OK}}, addr});
    exp_status.push_back(st);
  endfunction

  function void check_result(logic [47:0] d, logic [2:0] st);
    logic [47:0] ed;
    logic [2:0]  es;
    if (exp_data.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected result data=%h status=%0d", d, st);
      end
      return;
    end
    ed = exp_data.pop_front();
    es = exp_status.pop_front();
    if (d[31:0] !== ed[31:0] || d[44:32] !== ed[44:32] || st !== es) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch exp addr=%h bytes=%0d st=%0d got addr=%h bytes=%0d st=%0d",
                 ed[31:0], ed[44:32], es, d[31:0], d[44:32], st);
      end
    end
  endfunction
endclass

module size_ordered_free_list_allocator_tb;
  import sofl_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [31:0] cfg_wdata = '0;

  heap_scoreboard sb = new();
  int  cycles = 0;
  int  hold_cycles = 0;

  always #5 clk = ~clk;

  size_ordered_free_list_allocator dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // receiver side: random stalls plus a requested long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send(logic kind, logic [12:0] asz, logic [31:0] fa, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {3'b0, fa, asz};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, asz, fa);
  endtask

  task automatic drain();
    int lim;
    in_tvalid <= 0;
    lim = 0;
    while (sb.exp_data.size() != 0 && lim < 500000) begin
      @(posedge clk);
      lim++;
    end
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic random_item();
    logic [31:0] fa;
    int r, k;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send(1'b0, 13'((r < 45) ? $urandom_range(1, 200) : $urandom()), 32'($urandom()), 1);
    end else if (r < 88 && sb.granted.size() > 0) begin
      k = $urandom_range(0, sb.granted.size() - 1);
      fa = sb.granted[k];
      sb.granted.delete(k);
      send(1'b1, 13'($urandom()), fa, 1);
    end else begin
      fa = (r < 94) ? sb.base + 8 + ($urandom_range(0, 1100) & ~32'd0) : $urandom();
      send(1'b1, 13'($urandom()), fa, 1);
    end
  endtask

  task automatic phase(int n);
    for (int i = 0; i < n; i++) random_item();
  endtask

  initial begin
    logic [31:0] a;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed part
    send(1'b0, 13'd0, 32'hffffffff, 0);
    send(1'b0, 13'h1fff, 32'd0, 0);
    send(1'b0, 13'd4088, 32'd0, 0);
    send(1'b1, 13'h1fff, 32'd8, 0);
    send(1'b1, 13'd0, 32'd8, 0);
    send(1'b1, 13'd0, 32'd9, 0);
    send(1'b1, 13'd0, 32'd0, 0);
    send(1'b1, 13'd0, 32'hffffffff, 0);
    send(1'b0, 13'd1, 32'd0, 0);
    send(1'b0, 13'd13, 32'd0, 0);
    send(1'b0, 13'd4096, 32'd0, 0);
    while (sb.granted.size() > 0) begin
      a = sb.granted.pop_back();
      send(1'b1, 13'd0, a, 0);
    end
    drain();
    write_reg(CFG_BYTES, 32'd5);
    write_reg(CFG_BASE, 32'hfffffff0);
    send(1'b0, 13'd4, 32'd0, 0);
    send(1'b0, 13'd8, 32'd0, 0);
    send(1'b0, 13'd1, 32'd0, 0);
    send(1'b1, 13'd0, 32'hfffffff8, 0);
    send(1'b1, 13'd0, 32'h00000000, 0);
    drain();
    write_reg(CFG_BYTES, 32'h1fff);
    write_reg(CFG_BASE, 32'h00001000);
    // many small blocks then free every other one to fill the table
    for (int i = 0; i < 70; i++) send(1'b0, 13'd4, 32'd0, 1);
    for (int i = 0; i < sb.granted.size(); i += 2) send(1'b1, 13'd0, sb.granted[i], 1);
    drain();
    write_reg(CFG_BYTES, 32'd4096);
    phase(250);
    // receiver holds off while the sender keeps offering
    hold_cycles = 3000;
    phase(40);
    drain();
    write_reg(CFG_BYTES, 32'd600);
    write_reg(CFG_BASE, 32'($urandom()));
    phase(250);
    drain();
    write_reg(CFG_BYTES, 32'd16);
    phase(20);
    drain();
    write_reg(CFG_BYTES, 32'd2051);
    write_reg(CFG_BASE, 32'd0);
    phase(250);
    drain();
    if (sb.errors == 0 && sb.exp_data.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
